// ===== src/bc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the S3TC block decoder.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bc_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int CFG_W       = 13;
    localparam int POS_W       = 12;

    // Block format codes
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [63:0] color_word;
        logic [63:0] alpha_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      pixel_zero;
        logic [31:0]      pixel_one;
        logic [31:0]      pixel_two;
        logic [31:0]      pixel_three;
        logic [3:0]       pixel_mask;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_row;
        logic             image_done;
    } t_out_item;

    // Decoded palettes of one block: four RGBA colors and eight alphas.
    typedef struct packed {
        logic [3:0][31:0] color;
        logic [7:0][7:0]  alpha;
    } t_pal;

    typedef struct packed {
        logic [1:0] row;
        logic       last_block;
    } t_row_ctl;

    function automatic int blk_w(input int m);
        return (m > 4) ? $clog2(m) - 2 : 1;
    endfunction

    function automatic int dim_w(input int m);
        return $clog2(m + 1);
    endfunction

    // Width wide enough for pixel positions and dimension compares.
    function automatic int pos_cmp_w(input int m);
        int w;
        w = blk_w(m) + 3;
        if (dim_w(m) + 1 > w) w = dim_w(m) + 1;
        if (POS_W > w) w = POS_W;
        return w;
    endfunction

    // RGB565 to 24-bit color with R in bits 7:0.
    function automatic logic [23:0] expand565(input logic [15:0] v);
        return {v[4:0], v[4:2], v[10:5], v[10:9], v[15:11], v[15:13]};
    endfunction

    // Floor divisions by reciprocal multiplication, exact over the input range.
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [22:0] p;
        p = 23'(s) * 23'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [22:0] p;
        p = 23'(s) * 23'd2341;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

// ===== src/bc_palette.sv =====
// Builds the four-entry color palette and the eight-entry alpha palette of a block.
// Depends on bc_pkg for the palette type and the division helpers.
`timescale 1ns / 1ps
`default_nettype none

module bc_palette (
    input  wire logic [63:0] i_color_word,
    input  wire logic [63:0] i_alpha_word,
    input  wire logic [1:0]  i_fmt,
    output bc_pkg::t_pal     o_pal
);
    import bc_pkg::*;

    logic [15:0] e0, e1;
    logic [23:0] c0, c1;
    logic [23:0] mid, t2, t3;
    logic [7:0]  a0, a1;
    logic        three;

    always_comb begin
        e0    = i_color_word[15:0];
        e1    = i_color_word[31:16];
        c0    = expand565(e0);
        c1    = expand565(e1);
        a0    = i_alpha_word[7:0];
        a1    = i_alpha_word[15:8];
        three = (i_fmt != FMT_DXT3) && (i_fmt != FMT_DXT5) && (e0 <= e1);

        for (int ch = 0; ch < 3; ch++) begin
            mid[8*ch +: 8] = 8'((9'(c0[8*ch +: 8]) + 9'(c1[8*ch +: 8])) >> 1);
            t2[8*ch +: 8]  = div3({1'b0, c0[8*ch +: 8], 1'b0} + 10'(c1[8*ch +: 8]));
            t3[8*ch +: 8]  = div3(10'(c0[8*ch +: 8]) + {1'b0, c1[8*ch +: 8], 1'b0});
        end

        o_pal.color[0] = {8'hff, c0};
        o_pal.color[1] = {8'hff, c1};
        if (three) begin
            o_pal.color[2] = {8'hff, mid};
            o_pal.color[3] = 32'h0;
        end else begin
            o_pal.color[2] = {8'hff, t2};
            o_pal.color[3] = {8'hff, t3};
        end

        o_pal.alpha    = '0;
        o_pal.alpha[0] = a0;
        o_pal.alpha[1] = a1;
        if (a0 > a1) begin
            for (int i = 1; i < 7; i++) begin
                o_pal.alpha[1+i] = div7(11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i));
            end
        end else begin
            for (int i = 1; i < 5; i++) begin
                o_pal.alpha[1+i] = div5(11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i));
            end
            o_pal.alpha[6] = 8'h00;
            o_pal.alpha[7] = 8'hff;
        end
    end

endmodule

`default_nettype wire

// ===== src/bc_lane.sv =====
// One texel lane: picks the palette color and applies the format's alpha.
// Depends on bc_pkg for the palette type and format codes.
`timescale 1ns / 1ps
`default_nettype none

module bc_lane (
    input  wire bc_pkg::t_pal  i_pal,
    input  wire logic [1:0]    i_fmt,
    input  wire logic [1:0]    i_cidx,
    input  wire logic [3:0]    i_alpha4,
    input  wire logic [2:0]    i_aidx,
    output logic [31:0]        o_pixel
);
    import bc_pkg::*;

    logic [31:0] px;

    always_comb begin
        px = i_pal.color[i_cidx];
        case (i_fmt)
            FMT_DXT3: o_pixel = {i_alpha4, i_alpha4, px[23:0]};
            FMT_DXT5: o_pixel = {i_pal.alpha[i_aidx], px[23:0]};
            default:  o_pixel = px;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/bc_row_merge.sv =====
// Merges the four lane texels with the row position and crop mask into the output register.
// Depends on bc_pkg for the output item and row control types.
`timescale 1ns / 1ps
`default_nettype none

module bc_row_merge #(
    parameter int MAX_DIM = bc_pkg::MAX_DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_row_valid,
    input  wire bc_pkg::t_row_ctl                    i_ctl,
    input  wire logic [bc_pkg::blk_w(MAX_DIM)-1:0]   i_col,
    input  wire logic [bc_pkg::blk_w(MAX_DIM)-1:0]   i_brow,
    input  wire logic [3:0][31:0]                    i_pix,
    input  wire logic [bc_pkg::dim_w(MAX_DIM)-1:0]   i_width,
    input  wire logic [bc_pkg::dim_w(MAX_DIM)-1:0]   i_height,
    input  wire logic                                i_out_stall,
    output logic                                     o_take,
    output logic                                     o_out_valid,
    output bc_pkg::t_out_item                        o_out_data
);
    import bc_pkg::*;

    localparam int PW = pos_cmp_w(MAX_DIM);

    logic [PW-1:0] x, y;
    t_out_item     row;
    logic          r_out_valid;
    t_out_item     r_out_data;

    always_comb begin
        x = PW'({i_col, 2'b00});
        y = PW'({i_brow, 2'b00}) + PW'(i_ctl.row);
        for (int k = 0; k < 4; k++) begin
            row.pixel_mask[k] = (x + PW'(k) < PW'(i_width)) && (y < PW'(i_height));
        end
        row.pixel_zero  = i_pix[0];
        row.pixel_one   = i_pix[1];
        row.pixel_two   = i_pix[2];
        row.pixel_three = i_pix[3];
        row.pos_x       = x[POS_W-1:0];
        row.pos_y       = y[POS_W-1:0];
        row.last_row    = (i_ctl.row == 2'd3);
        row.image_done  = (i_ctl.row == 2'd3) && i_ctl.last_block;
    end

    // The register takes a new row when empty or when its row is transferred now.
    assign o_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_row_valid) begin
            r_out_data <= row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/bc1_bc2_bc3_block_decoder.sv =====
// S3TC (DXT1/DXT3/DXT5) block decoder, top level. Uses bc_pkg, bc_palette, bc_lane, bc_row_merge.
// Each block passes through the stage 1 register, the stage 2 palette register and the output register.
// The four rows of a block leave through one output register, which holds while the output stalls;
// a new block is taken while the previous one is still emitting rows.
// Reset (synchronous, active low): format DXT1, image 4x4, block counter 0, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module bc1_bc2_bc3_block_decoder #(
    parameter int MAX_DIM = bc_pkg::MAX_DIM_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire bc_pkg::t_in_item           i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output bc_pkg::t_out_item               o_out_data,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [bc_pkg::CFG_W-1:0]   i_cfg_data
);
    import bc_pkg::*;

    localparam int BLK_W = blk_w(MAX_DIM);
    localparam int DIM_W = dim_w(MAX_DIM);
    localparam int EW    = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
    localparam int CW    = ((DIM_W > BLK_W) ? DIM_W : BLK_W) + 1;

    // Configuration
    logic [1:0]       r_fmt;
    logic [CFG_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] w, h;
    logic [CW-1:0]    bx, by;

    // Block counter
    logic [BLK_W-1:0] r_col, r_brow, n_col, n_brow;
    logic [CW-1:0]    col_p1, row_p1;
    logic             last_blk;

    // Stage 1: accepted block
    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic [BLK_W-1:0] r_s1_col, r_s1_brow;
    logic             r_s1_last;

    // Stage 2: decoded palettes, rows leave one per cycle unless the output stalls
    logic             r_s2_valid;
    logic [1:0]       r_row;
    t_pal             r_pal;
    logic [31:0]      r_cidx;
    logic [63:0]      r_a3;
    logic [47:0]      r_a5;
    logic [BLK_W-1:0] r_s2_col, r_s2_brow;
    logic             r_s2_last;

    t_pal             pal;
    logic [3:0][31:0] lane_pix;
    t_row_ctl         row_ctl;
    logic             take, in_xfer, s2_adv, s2_free, s1_move;

    always_comb begin
        if (r_width == '0) begin
            w = DIM_W'(1);
        end else if (EW'(r_width) > EW'(MAX_DIM)) begin
            w = DIM_W'(MAX_DIM);
        end else begin
            w = DIM_W'(r_width);
        end
        if (r_height == '0) begin
            h = DIM_W'(1);
        end else if (EW'(r_height) > EW'(MAX_DIM)) begin
            h = DIM_W'(MAX_DIM);
        end else begin
            h = DIM_W'(r_height);
        end
        bx = (CW'(w) + CW'(3)) >> 2;
        by = (CW'(h) + CW'(3)) >> 2;
    end

    always_comb begin
        col_p1   = CW'(r_col) + CW'(1);
        row_p1   = CW'(r_brow) + CW'(1);
        last_blk = (col_p1 == bx) && (row_p1 == by);
        n_col    = col_p1[BLK_W-1:0];
        n_brow   = r_brow;
        // A counter left outside the image by a resize still wraps at the next compare.
        if (col_p1 >= bx) begin
            n_col  = '0;
            n_brow = (row_p1 >= by) ? '0 : row_p1[BLK_W-1:0];
        end
    end

    assign s2_adv     = r_s2_valid && take;
    assign s2_free    = !r_s2_valid || (s2_adv && (r_row == 2'd3));
    assign s1_move    = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_DXT1;
            r_width    <= CFG_W'(4);
            r_height   <= CFG_W'(4);
            r_col      <= '0;
            r_brow     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_row      <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FORMAT: r_fmt    <= i_cfg_data[1:0];
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (in_xfer) begin
                r_col  <= n_col;
                r_brow <= n_brow;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
                r_row      <= 2'd0;
            end else if (s2_adv) begin
                r_row <= r_row + 2'd1;
                if (r_row == 2'd3) begin
                    r_s2_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_data;
            r_s1_col  <= r_col;
            r_s1_brow <= r_brow;
            r_s1_last <= last_blk;
        end
        if (s1_move) begin
            r_pal     <= pal;
            r_cidx    <= r_s1_item.color_word[63:32];
            r_a3      <= r_s1_item.alpha_word;
            r_a5      <= r_s1_item.alpha_word[63:16];
            r_s2_col  <= r_s1_col;
            r_s2_brow <= r_s1_brow;
            r_s2_last <= r_s1_last;
        end else if (s2_adv) begin
            // The index words shift so the lanes always read the current row at the bottom.
            r_cidx <= r_cidx >> 8;
            r_a3   <= r_a3 >> 16;
            r_a5   <= r_a5 >> 12;
        end
    end

    bc_palette u_palette (
        .i_color_word (r_s1_item.color_word),
        .i_alpha_word (r_s1_item.alpha_word),
        .i_fmt        (r_fmt),
        .o_pal        (pal)
    );

    for (genvar k = 0; k < 4; k++) begin : g_lane
        bc_lane u_lane (
            .i_pal    (r_pal),
            .i_fmt    (r_fmt),
            .i_cidx   (r_cidx[2*k +: 2]),
            .i_alpha4 (r_a3[4*k +: 4]),
            .i_aidx   (r_a5[3*k +: 3]),
            .o_pixel  (lane_pix[k])
        );
    end

    assign row_ctl.row        = r_row;
    assign row_ctl.last_block = r_s2_last;

    bc_row_merge #(
        .MAX_DIM (MAX_DIM)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_valid (r_s2_valid),
        .i_ctl       (row_ctl),
        .i_col       (r_s2_col),
        .i_brow      (r_s2_brow),
        .i_pix       (lane_pix),
        .i_width     (w),
        .i_height    (h),
        .i_out_stall (i_out_stall),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_done_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.image_done |-> o_out_data.last_row)
        else $error("image_done without last_row");

    a_row_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row != 2'd0) |-> r_s2_valid)
        else $error("row counter mid-block with empty stage");

    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_row
        |=> o_out_valid && (o_out_data.pos_y == $past(o_out_data.pos_y) + 12'd1))
        else $error("next row of a block missing or misplaced");

endmodule

`default_nettype wire

// ===== tb/sv/bc_row_check.sv =====
// Row checker for the S3TC block decoder: predicts the four texel rows of each
// accepted block and compares them with the rows leaving the output channel.
// Depends on bc_pkg for the transfer types and the format and register codes.
`timescale 1ns / 1ps

module bc_row_check (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  bc_pkg::t_in_item         i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  bc_pkg::t_out_item        i_out_data,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [bc_pkg::CFG_W-1:0] i_cfg_data,
    output int                       o_rows_pending,
    output int                       o_mismatches
);
    import bc_pkg::*;

    logic [1:0]       fmt;
    logic [CFG_W-1:0] img_w;
    logic [CFG_W-1:0] img_h;
    logic [9:0]       blk_col;
    logic [9:0]       blk_row;
    t_out_item        rows_due[$];
    t_out_item        want;
    int               mismatch_count = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
        return d;
    endfunction

    // Widen a 5- or 6-bit channel to 8 bits by repeating its top bits.
    function automatic int unsigned widen(input int unsigned v, input int unsigned bits);
        return (bits == 6) ? ((v << 2) | (v >> 4)) : ((v << 3) | (v >> 2));
    endfunction

    function automatic logic [31:0] rgba(input int unsigned r, g, b, a);
        return 32'(r | (g << 8) | (b << 16) | (a << 24));
    endfunction

    function automatic logic [15:0][31:0] decode_texels(input t_in_item blk,
                                                        input logic [1:0] f);
        int unsigned      e0, e1, a0, a1, i;
        int unsigned      c0[3];
        int unsigned      c1[3];
        int unsigned      apal[8];
        logic [31:0]      pal[4];
        logic [15:0][31:0] tex;
        logic             three_color;
        e0 = blk.color_word[15:0];
        e1 = blk.color_word[31:16];
        c0[0] = widen((e0 >> 11) & 'h1f, 5);
        c0[1] = widen((e0 >> 5) & 'h3f, 6);
        c0[2] = widen(e0 & 'h1f, 5);
        c1[0] = widen((e1 >> 11) & 'h1f, 5);
        c1[1] = widen((e1 >> 5) & 'h3f, 6);
        c1[2] = widen(e1 & 'h1f, 5);
        three_color = (f != FMT_DXT3) && (f != FMT_DXT5) && (e0 <= e1);
        pal[0] = rgba(c0[0], c0[1], c0[2], 255);
        pal[1] = rgba(c1[0], c1[1], c1[2], 255);
        if (three_color) begin
            pal[2] = rgba((c0[0] + c1[0]) / 2, (c0[1] + c1[1]) / 2,
                          (c0[2] + c1[2]) / 2, 255);
            pal[3] = '0;
        end else begin
            pal[2] = rgba((2 * c0[0] + c1[0]) / 3, (2 * c0[1] + c1[1]) / 3,
                          (2 * c0[2] + c1[2]) / 3, 255);
            pal[3] = rgba((c0[0] + 2 * c1[0]) / 3, (c0[1] + 2 * c1[1]) / 3,
                          (c0[2] + 2 * c1[2]) / 3, 255);
        end

        a0 = blk.alpha_word[7:0];
        a1 = blk.alpha_word[15:8];
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (i = 1; i < 7; i++) apal[1 + i] = ((7 - i) * a0 + i * a1) / 7;
        end else begin
            for (i = 1; i < 5; i++) apal[1 + i] = ((5 - i) * a0 + i * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        for (i = 0; i < 16; i++) begin
            tex[i] = pal[blk.color_word[32 + 2 * i +: 2]];
            if (f == FMT_DXT3) begin
                tex[i][31:24] = 8'(blk.alpha_word[4 * i +: 4] * 17);
            end else if (f == FMT_DXT5) begin
                tex[i][31:24] = 8'(apal[blk.alpha_word[16 + 3 * i +: 3]]);
            end
        end
        return tex;
    endfunction

    task automatic push_block_rows(input t_in_item blk);
        int unsigned       w, h, bx, by, col, row, x, y, r, k;
        logic [15:0][31:0] tex;
        logic              last_block;
        t_out_item         exp_row;
        w = clamp_dim(img_w);
        h = clamp_dim(img_h);
        bx = (w + 3) / 4;
        by = (h + 3) / 4;
        col = blk_col;
        row = blk_row;
        x = col * 4;
        last_block = (col + 1 == bx) && (row + 1 == by);
        tex = decode_texels(blk, fmt);
        for (r = 0; r < 4; r++) begin
            y = row * 4 + r;
            exp_row.pixel_zero  = tex[4 * r];
            exp_row.pixel_one   = tex[4 * r + 1];
            exp_row.pixel_two   = tex[4 * r + 2];
            exp_row.pixel_three = tex[4 * r + 3];
            exp_row.pixel_mask  = '0;
            for (k = 0; k < 4; k++) exp_row.pixel_mask[k] = (x + k < w) && (y < h);
            exp_row.pos_x      = POS_W'(x);
            exp_row.pos_y      = POS_W'(y);
            exp_row.last_row   = (r == 3);
            exp_row.image_done = (r == 3) && last_block;
            rows_due.insert(rows_due.size(), exp_row);
        end
        // Raster walk; a counter left outside a shrunk image wraps on its next block.
        if (col + 1 >= bx) begin
            blk_col = '0;
            if (row + 1 >= by) blk_row = '0;
            else blk_row = blk_row + 1'b1;
        end else begin
            blk_col = blk_col + 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got);
        if (exp_val !== got) begin
            $error("%s: expected %h, got %h", name, exp_val, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt = FMT_DXT1;
            img_w = 4;
            img_h = 4;
            blk_col = '0;
            blk_row = '0;
            rows_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FORMAT: fmt = i_cfg_data[1:0];
                    REG_WIDTH:  img_w = i_cfg_data;
                    REG_HEIGHT: img_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) push_block_rows(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (rows_due.size() == 0) begin
                    $error("row transfer with no row expected");
                    mismatch_count++;
                end else begin
                    want = rows_due.pop_front();
                    check_field("pixel_zero", want.pixel_zero, i_out_data.pixel_zero);
                    check_field("pixel_one", want.pixel_one, i_out_data.pixel_one);
                    check_field("pixel_two", want.pixel_two, i_out_data.pixel_two);
                    check_field("pixel_three", want.pixel_three, i_out_data.pixel_three);
                    check_field("pixel_mask", 32'(want.pixel_mask), 32'(i_out_data.pixel_mask));
                    check_field("pos_x", 32'(want.pos_x), 32'(i_out_data.pos_x));
                    check_field("pos_y", 32'(want.pos_y), 32'(i_out_data.pos_y));
                    check_field("last_row", 32'(want.last_row), 32'(i_out_data.last_row));
                    check_field("image_done", 32'(want.image_done),
                                32'(i_out_data.image_done));
                end
            end
        end
        o_rows_pending <= rows_due.size();
        o_mismatches   <= mismatch_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the S3TC block decoder: drives blocks and register writes,
// stalls the row output, and reports the verdict of the row checker.
// Depends on bc_pkg, bc1_bc2_bc3_block_decoder and bc_row_check.
`timescale 1ns / 1ps

module tb;
    import bc_pkg::*;

    localparam logic [1:0]  REG_SPARE  = 2'd3;
    localparam logic [1:0]  FMT_SPARE  = 2'd3;
    localparam logic [31:0] IDX_RAMP   = 32'hE4E4_E4E4;       // indices 0,1,2,3 per row
    localparam logic [47:0] APAL_RAMP  = 48'hFAC688_FAC688;   // palette entries 0..7 twice
    localparam logic [63:0] NIBBLE_RAMP = 64'hFEDC_BA98_7654_3210;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = REG_FORMAT;
    logic [CFG_W-1:0] cfg_data = '0;
    int               rows_pending;
    int               mismatches;
    int               burst_left = 0;
    bit               burst_open = 1'b0;
    t_stall_mode      stall_mode = STALL_NONE;
    int               stall_left = 0;
    int               stall_tick = 0;

    always #6 clk = ~clk;

    bc1_bc2_bc3_block_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bc_row_check u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_rows_pending (rows_pending),
        .o_mismatches   (mismatches)
    );

    // Output stall: a random mode is picked anew each time the previous one runs out.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((stall_tick % 5) < 2);
            endcase
        end
    end

    function automatic t_in_item make_block(input logic [15:0] e0, e1,
                                            input logic [31:0] idx,
                                            input logic [63:0] aw);
        t_in_item blk;
        blk.color_word = {idx, e1, e0};
        blk.alpha_word = aw;
        return blk;
    endfunction

    function automatic t_in_item random_block();
        t_in_item blk;
        blk.color_word = {$urandom, $urandom};
        blk.alpha_word = {$urandom, $urandom};
        // Steer the endpoint order so both palette modes and the tie are hit often.
        case ($urandom_range(0, 3))
            1: blk.color_word[31:16] = blk.color_word[15:0];
            2: if (blk.color_word[15:0] > blk.color_word[31:16])
                   blk.color_word[31:0] = {blk.color_word[15:0], blk.color_word[31:16]};
            3: if (blk.color_word[15:0] < blk.color_word[31:16])
                   blk.color_word[31:0] = {blk.color_word[15:0], blk.color_word[31:16]};
            default: ;
        endcase
        case ($urandom_range(0, 3))
            1: blk.alpha_word[15:8] = blk.alpha_word[7:0];
            2: if (blk.alpha_word[7:0] > blk.alpha_word[15:8])
                   blk.alpha_word[15:0] = {blk.alpha_word[7:0], blk.alpha_word[15:8]};
            3: if (blk.alpha_word[7:0] < blk.alpha_word[15:8])
                   blk.alpha_word[15:0] = {blk.alpha_word[7:0], blk.alpha_word[15:8]};
            default: ;
        endcase
        return blk;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(MAX_DIM_DEF);
            2: return CFG_W'($urandom_range(MAX_DIM_DEF + 1, (1 << CFG_W) - 1));
            3: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_format();
        logic [1:0] f;
        f = 2'($urandom_range(0, 3));
        // The upper data bits are don't-care for the format register.
        if ($urandom_range(0, 3) == 0) return {11'($urandom), f};
        return CFG_W'(f);
    endfunction

    // Writes every register once, in a rotated order from a random start, keeping valid high throughout.
    task automatic write_regs(input logic [CFG_W-1:0] fmt_word, w, h);
        logic [1:0] order[4];
        logic [1:0] idx;
        int         first, n;
        order = '{REG_FORMAT, REG_WIDTH, REG_HEIGHT, REG_SPARE};
        first = $urandom_range(0, 3);
        for (n = 0; n < 4; n++) begin
            idx = order[(first + n) % 4];
            cfg_index <= idx;
            case (idx)
                REG_FORMAT: cfg_data <= fmt_word;
                REG_WIDTH:  cfg_data <= w;
                REG_HEIGHT: cfg_data <= h;
                default:    cfg_data <= CFG_W'($urandom);
            endcase
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input t_in_item blk);
        in_data  <= blk;
        in_valid <= 1'b1;
        burst_open = 1'b1;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            burst_open = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Holds the input off until every expected row has left the block.
    task automatic wait_drained();
        if (burst_open) begin
            in_valid <= 1'b0;
            burst_open = 1'b0;
        end
        do @(posedge clk); while (rows_pending != 0);
    endtask

    initial begin
        int ph, n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: DXT1, one 4x4 block per image.
        send_block(make_block(16'h0000, 16'h0000, 32'h0, 64'h0));
        send_block(make_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_block(make_block(16'hF800, 16'h001F, IDX_RAMP, 64'h0));
        send_block(make_block(16'h001F, 16'h07E0, IDX_RAMP, 64'h0));
        send_block(make_block(16'h8410, 16'h8410, IDX_RAMP, 64'h0));

        // Explicit alpha on a cropped 2x2-block image.
        wait_drained();
        write_regs(CFG_W'(FMT_DXT3), 13'd5, 13'd6);
        send_block(make_block(16'hF81F, 16'h07E0, IDX_RAMP, NIBBLE_RAMP));
        send_block(make_block(16'h1234, 16'hABCD, IDX_RAMP, 64'hFFFF_FFFF_FFFF_FFFF));
        send_block(make_block(16'h0001, 16'hFFFE, 32'h1B1B_1B1B, 64'h0));
        send_block(random_block());

        // Interpolated alpha, both palette sizes; zero dimensions clamp to one.
        wait_drained();
        write_regs(CFG_W'(FMT_DXT5), 13'd0, 13'd0);
        send_block(make_block(16'hFFFF, 16'h0000, IDX_RAMP, {APAL_RAMP, 8'd10, 8'd200}));
        send_block(make_block(16'hFFFF, 16'h0000, IDX_RAMP, {APAL_RAMP, 8'd200, 8'd10}));
        send_block(make_block(16'hFFFF, 16'h0000, IDX_RAMP, {APAL_RAMP, 8'd77, 8'd77}));
        send_block(make_block(16'h0000, 16'hFFFF, IDX_RAMP, {APAL_RAMP, 8'd0, 8'd255}));
        send_block(make_block(16'h0000, 16'hFFFF, IDX_RAMP, {APAL_RAMP, 8'd255, 8'd0}));

        // Unused format code and oversized dimensions.
        wait_drained();
        write_regs(CFG_W'(FMT_SPARE), 13'h1FFF, 13'd4097);
        send_block(make_block(16'h0010, 16'h0200, IDX_RAMP, NIBBLE_RAMP));
        send_block(make_block(16'h0200, 16'h0010, IDX_RAMP, NIBBLE_RAMP));
        send_block(random_block());

        // Shrinking the image leaves the block counter outside it.
        wait_drained();
        write_regs(CFG_W'(FMT_DXT1), 13'd4, 13'd1);
        send_block(random_block());
        send_block(random_block());

        wait_drained();
        write_regs(CFG_W'(FMT_DXT5), CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF));
        send_block(random_block());
        send_block(random_block());

        wait_drained();
        write_regs(CFG_W'(FMT_DXT3), 13'd1, 13'd1);
        send_block(random_block());

        for (ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_regs(pick_format(), pick_dim(), pick_dim());
            for (n = 0; n < 50; n++) begin
                if (n == 25 && $urandom_range(0, 1) == 1) wait_drained();
                send_block(random_block());
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS bc1_bc2_bc3_block_decoder");
        end else begin
            $display("FAIL bc1_bc2_bc3_block_decoder");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL bc1_bc2_bc3_block_decoder");
        $finish;
    end

endmodule
